// ----- rtl/abb_pkg.sv -----
// Shared constants and types for the alpha bounding box block.
package abb_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int DIM_W           = 13;
    localparam int SPAN_W          = 14;
    localparam int ALPHA_W         = 8;
    localparam int IDX_W           = 48;
    localparam int CODE_W          = 3;
    localparam int BLOCK_DIM       = 4;
    localparam int PIXELS_PER_BLK  = BLOCK_DIM * BLOCK_DIM;
    localparam int PAL_SIZE        = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;
    localparam logic [1:0] REG_MODE      = 2'd3;

    typedef enum logic {
        MODE_BLOCK = 1'b0,
        MODE_PIXEL = 1'b1
    } t_mode;

    // configuration as seen by front and back, sizes already clamped
    typedef struct packed {
        logic [ALPHA_W-1:0] thr;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        t_mode              mode;
    } t_cfg;

    // classified item: which block columns and rows hold a passing pixel
    typedef struct packed {
        logic [DIM_W-1:0]     base_col;
        logic [DIM_W-1:0]     base_row;
        logic [BLOCK_DIM-1:0] col_mask;
        logic [BLOCK_DIM-1:0] row_mask;
        logic                 last;
    } t_entry;

endpackage

// ----- rtl/abb_in_if.sv -----
// Input item channel: one alpha block or one alpha byte.
interface abb_in_if;
    import abb_pkg::*;

    logic               valid;
    logic               ready;
    logic [ALPHA_W-1:0] alpha_end0;
    logic [ALPHA_W-1:0] alpha_end1;
    logic [IDX_W-1:0]   alpha_indices;
    logic [ALPHA_W-1:0] pixel_alpha;

    modport source (
        output valid, alpha_end0, alpha_end1, alpha_indices, pixel_alpha,
        input  ready
    );
    modport sink (
        input  valid, alpha_end0, alpha_end1, alpha_indices, pixel_alpha,
        output ready
    );
endinterface

// ----- rtl/abb_out_if.sv -----
// Result channel: crop box of one image.
interface abb_out_if;
    import abb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [DIM_W-1:0]         box_left;
    logic [DIM_W-1:0]         box_top;
    logic signed [SPAN_W-1:0] box_width;
    logic signed [SPAN_W-1:0] box_height;
    logic                     any_found;

    modport source (
        output valid, box_left, box_top, box_width, box_height, any_found,
        input  ready
    );
    modport sink (
        input  valid, box_left, box_top, box_width, box_height, any_found,
        output ready
    );
endinterface

// ----- rtl/abb_front.sv -----
// Front end: takes items, decodes alpha, tracks the scan cursor.
module abb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abb_pkg::t_cfg  i_cfg,
    abb_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output abb_pkg::t_entry o_entry
);
    import abb_pkg::*;

    localparam int PAL_W = 11;

    logic [DIM_W-1:0]     r_col, r_row, n_col, n_row;
    logic [DIM_W-1:0]     stride, col_step, row_step;
    logic                 take, last;
    logic [PAL_SIZE-1:0]  pal_pass;
    logic [BLOCK_DIM-1:0] col_ok, row_ok, col_mask, row_mask;

    assign i_in.ready = !i_full;
    assign take       = i_in.valid && !i_full;
    assign o_push     = take;

    // Palette compare without division: floor((x + r) / d) > t  <=>  x + r >= d * (t + 1)
    always_comb begin
        logic [PAL_W-1:0] a0, a1, lim7, lim5, x;
        a0   = PAL_W'(i_in.alpha_end0);
        a1   = PAL_W'(i_in.alpha_end1);
        lim7 = PAL_W'(i_cfg.thr) * PAL_W'(7) + PAL_W'(7);
        lim5 = PAL_W'(i_cfg.thr) * PAL_W'(5) + PAL_W'(5);
        x    = '0;
        pal_pass    = '0;
        pal_pass[0] = i_in.alpha_end0 > i_cfg.thr;
        pal_pass[1] = i_in.alpha_end1 > i_cfg.thr;
        if (i_in.alpha_end0 > i_in.alpha_end1) begin
            for (int k = 1; k <= 6; k++) begin
                x = PAL_W'(7 - k) * a0 + PAL_W'(k) * a1 + PAL_W'(3);
                pal_pass[k + 1] = x >= lim7;
            end
        end else begin
            for (int k = 1; k <= 4; k++) begin
                x = PAL_W'(5 - k) * a0 + PAL_W'(k) * a1 + PAL_W'(2);
                pal_pass[k + 1] = x >= lim5;
            end
            pal_pass[6] = 1'b0;                       // entry 0x00 never passes
            pal_pass[7] = i_cfg.thr != 8'hFF;         // entry 0xFF
        end
    end

    always_comb begin
        for (int c = 0; c < BLOCK_DIM; c++) begin
            col_ok[c] = (r_col + DIM_W'(c)) < i_cfg.width;
            row_ok[c] = (r_row + DIM_W'(c)) < i_cfg.height;
        end
        col_mask = '0;
        row_mask = '0;
        if (i_cfg.mode == MODE_BLOCK) begin
            for (int p = 0; p < PIXELS_PER_BLK; p++) begin
                if (pal_pass[i_in.alpha_indices[CODE_W*p +: CODE_W]]
                        && col_ok[p % BLOCK_DIM] && row_ok[p / BLOCK_DIM]) begin
                    col_mask[p % BLOCK_DIM] = 1'b1;
                    row_mask[p / BLOCK_DIM] = 1'b1;
                end
            end
        end else begin
            col_mask[0] = (i_in.pixel_alpha > i_cfg.thr) && col_ok[0] && row_ok[0];
            row_mask[0] = col_mask[0];
        end
    end

    // cursor advance; wrap at the right edge, image ends past the bottom
    always_comb begin
        stride   = (i_cfg.mode == MODE_BLOCK) ? DIM_W'(BLOCK_DIM) : DIM_W'(1);
        col_step = r_col + stride;
        row_step = r_row + stride;
        n_col    = r_col;
        n_row    = r_row;
        last     = 1'b0;
        if (col_step < i_cfg.width) begin
            n_col = col_step;
        end else if (row_step < i_cfg.height) begin
            n_col = '0;
            n_row = row_step;
        end else begin
            n_col = '0;
            n_row = '0;
            last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_entry = '{base_col: r_col, base_row: r_row,
                       col_mask: col_mask, row_mask: row_mask, last: last};

endmodule

// ----- rtl/abb_queue.sv -----
// Short FIFO of classified items between front and back.
module abb_queue #(
    parameter int DEPTH = abb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abb_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output abb_pkg::t_entry o_data,
    output logic            o_empty
);
    import abb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/abb_back.sv -----
// Back end: folds classified items into the box and emits the result.
module abb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abb_pkg::t_cfg   i_cfg,
    input  abb_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    abb_out_if.source       o_out
);
    import abb_pkg::*;

    function automatic logic [1:0] low_idx(logic [BLOCK_DIM-1:0] m);
        logic [1:0] r;
        r = 2'(BLOCK_DIM - 1);
        for (int i = BLOCK_DIM - 1; i >= 0; i--) begin
            if (m[i]) r = 2'(i);
        end
        return r;
    endfunction

    function automatic logic [1:0] high_idx(logic [BLOCK_DIM-1:0] m);
        logic [1:0] r;
        r = '0;
        for (int i = 0; i < BLOCK_DIM; i++) begin
            if (m[i]) r = 2'(i);
        end
        return r;
    endfunction

    logic [DIM_W-1:0]  r_min_col, r_max_col, r_min_row, r_max_row;
    logic [DIM_W-1:0]  n_min_col, n_max_col, n_min_row, n_max_row;
    logic              r_seen, n_seen;
    logic [DIM_W-1:0]  it_min_col, it_max_col, it_min_row, it_max_row;
    logic              it_any;

    logic                     r_out_valid;
    logic [DIM_W-1:0]         r_left, r_top, n_left, n_top;
    logic signed [SPAN_W-1:0] r_bw, r_bh, n_bw, n_bh;
    logic                     r_found;

    // a final item waits while the previous result is still unclaimed
    assign o_pop = !i_empty && (!i_entry.last || !r_out_valid || o_out.ready);

    always_comb begin
        it_any     = |i_entry.col_mask;
        it_min_col = i_entry.base_col + DIM_W'(low_idx(i_entry.col_mask));
        it_max_col = i_entry.base_col + DIM_W'(high_idx(i_entry.col_mask));
        it_min_row = i_entry.base_row + DIM_W'(low_idx(i_entry.row_mask));
        it_max_row = i_entry.base_row + DIM_W'(high_idx(i_entry.row_mask));

        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_seen    = r_seen | it_any;
        if (it_any) begin
            if (it_min_col < r_min_col) n_min_col = it_min_col;
            if (it_max_col > r_max_col) n_max_col = it_max_col;
            if (it_min_row < r_min_row) n_min_row = it_min_row;
            if (it_max_row > r_max_row) n_max_row = it_max_row;
        end

        if (n_seen) begin
            n_left = n_min_col;
            n_top  = n_min_row;
            n_bw   = SPAN_W'({1'b0, n_max_col}) + SPAN_W'(1) - SPAN_W'({1'b0, n_min_col});
            n_bh   = SPAN_W'({1'b0, n_max_row}) + SPAN_W'(1) - SPAN_W'({1'b0, n_min_row});
        end else begin
            n_left = i_cfg.width;
            n_top  = i_cfg.height;
            n_bw   = SPAN_W'(0) - SPAN_W'({1'b0, i_cfg.width});
            n_bh   = SPAN_W'(0) - SPAN_W'({1'b0, i_cfg.height});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col <= '1;
            r_max_col <= '0;
            r_min_row <= '1;
            r_max_row <= '0;
            r_seen    <= 1'b0;
        end else if (o_pop) begin
            if (i_entry.last) begin
                r_min_col <= '1;
                r_max_col <= '0;
                r_min_row <= '1;
                r_max_row <= '0;
                r_seen    <= 1'b0;
            end else begin
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_seen    <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_left  <= n_left;
            r_top   <= n_top;
            r_bw    <= n_bw;
            r_bh    <= n_bh;
            r_found <= n_seen;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.box_left   = r_left;
    assign o_out.box_top    = r_top;
    assign o_out.box_width  = r_bw;
    assign o_out.box_height = r_bh;
    assign o_out.any_found  = r_found;

endmodule

// ----- rtl/alpha_bounding_box_bc3.sv -----
// Top level of the alpha crop-box finder with BC3 alpha block decode.
//
//  channel  | dir | handshake            | carries
//  ---------+-----+----------------------+------------------------------------------
//  i_in     | in  | valid/ready          | alpha_end0, alpha_end1, alpha_indices,
//           |     |                      | pixel_alpha
//  o_out    | out | valid/ready          | box_left, box_top, box_width, box_height,
//           |     |                      | any_found
//  apb      | in  | psel/penable, pready | four config registers at 0x0..0xC
//
// One item per cycle when the queue has room; the front decodes 16 pixels at once.
// The last item of an image passes the item queue, then the result register.
// The item queue (QUEUE_DEPTH entries) lets the front keep taking items while
// a result waits; input stalls only when the queue fills.
// Synchronous reset clears the cursor, the box and the queue; no clearing pass.
module alpha_bounding_box_bc3 #(
    parameter int QUEUE_DEPTH = abb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    abb_in_if.sink                         i_in,
    abb_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [abb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [abb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [abb_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import abb_pkg::*;

    logic [ALPHA_W-1:0] r_thr;
    logic [DIM_W-1:0]   r_width, r_height;
    t_mode              r_mode;
    logic               wr_en;
    logic [1:0]         reg_idx;
    t_cfg               cfg;
    logic               q_push, q_pop, q_full, q_empty;
    t_entry             q_in, q_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_width  <= DIM_W'(64);
            r_height <= DIM_W'(64);
            r_mode   <= MODE_BLOCK;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_thr    <= pwdata[ALPHA_W-1:0];
                REG_WIDTH:     r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT:    r_height <= pwdata[DIM_W-1:0];
                REG_MODE:      r_mode   <= t_mode'(pwdata[0]);
                default:       ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(r_thr);
            REG_WIDTH:     prdata = APB_DATA_W'(r_width);
            REG_HEIGHT:    prdata = APB_DATA_W'(r_height);
            REG_MODE:      prdata = APB_DATA_W'(r_mode);
            default:       prdata = '0;
        endcase
    end

    // zero size acts as one, oversize as the maximum
    always_comb begin
        cfg.thr  = r_thr;
        cfg.mode = r_mode;
        if (r_width == '0) begin
            cfg.width = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_DIM)) begin
            cfg.width = DIM_W'(MAX_DIM);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == '0) begin
            cfg.height = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_DIM)) begin
            cfg.height = DIM_W'(MAX_DIM);
        end else begin
            cfg.height = r_height;
        end
    end

    abb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    abb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    abb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_entry (q_out),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// ----- tb/sv/alpha_bounding_box_bc3_tb.sv -----
// Self-checking testbench for the alpha crop-box finder: directed table, then random images.
module alpha_bounding_box_bc3_tb;
    import abb_pkg::*;

    localparam int SETTLE_CYCLES = 12;      // settling wait for the output register and the item queue to drain
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_ITEMS    = 1600;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [ALPHA_W-1:0] thr;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        t_mode              mode;
    } t_img_cfg;

    typedef struct packed {
        logic [ALPHA_W-1:0] e0;
        logic [ALPHA_W-1:0] e1;
        logic [IDX_W-1:0]   idx;
        logic [ALPHA_W-1:0] pix;
    } t_alpha_item;

    typedef struct packed {
        logic [DIM_W-1:0]         left;
        logic [DIM_W-1:0]         top;
        logic signed [SPAN_W-1:0] wd;
        logic signed [SPAN_W-1:0] ht;
        logic                     found;
    } t_box;

    typedef struct packed {
        t_img_cfg    cfg;
        t_alpha_item item;
        logic        typed;
        t_box        box;
    } t_dir_row;

    localparam t_img_cfg CFG_A = '{8'd0,   13'd4, 13'd4, MODE_BLOCK};
    localparam t_img_cfg CFG_B = '{8'd255, 13'd4, 13'd4, MODE_BLOCK};
    localparam t_img_cfg CFG_C = '{8'd254, 13'd2, 13'd2, MODE_PIXEL};
    localparam t_img_cfg CFG_D = '{8'd0,   13'd0, 13'd0, MODE_BLOCK};
    localparam t_img_cfg CFG_E = '{8'd100, 13'd6, 13'd5, MODE_BLOCK};
    localparam t_img_cfg CFG_F = '{8'd0,   13'd3, 13'd2, MODE_PIXEL};
    localparam t_img_cfg CFG_G = '{8'd0,   13'd2, 13'd2, MODE_PIXEL};
    localparam t_img_cfg CFG_H = '{8'd0,   13'd2, 13'd2, MODE_BLOCK};

    localparam t_box NO_BOX    = '0;
    localparam t_box EMPTY_4X4 = '{13'd4, 13'd4, -14'sd4, -14'sd4, 1'b0};
    localparam t_box FULL_4X4  = '{13'd0, 13'd0, 14'sd4, 14'sd4, 1'b1};
    localparam t_box ONE_AT_11 = '{13'd1, 13'd1, 14'sd1, 14'sd1, 1'b1};
    localparam t_box ONE_AT_33 = '{13'd3, 13'd3, 14'sd1, 14'sd1, 1'b1};
    localparam t_box EMPTY_1X1 = '{13'd1, 13'd1, -14'sd1, -14'sd1, 1'b0};

    t_dir_row dir_tab [22] = '{
        // all-zero block, full block from endpoint 0, full block from code 7, one code-7 pixel
        '{CFG_A, '{8'd0,   8'd0,   48'h0000_0000_0000, 8'h00}, 1'b1, EMPTY_4X4},
        '{CFG_A, '{8'd255, 8'd0,   48'h0000_0000_0000, 8'h00}, 1'b1, FULL_4X4},
        '{CFG_A, '{8'd0,   8'd0,   48'hFFFF_FFFF_FFFF, 8'h00}, 1'b1, FULL_4X4},
        '{CFG_A, '{8'd0,   8'd0,   48'h0000_0003_8000, 8'h00}, 1'b1, ONE_AT_11},
        // eight-step, six-step, equal endpoints, one endpoint-1 pixel
        '{CFG_A, '{8'd200, 8'd100, 48'hFAC6_88D1_3B05, 8'h00}, 1'b0, NO_BOX},
        '{CFG_A, '{8'd100, 8'd200, 48'h05D3_E219_7A4C, 8'h00}, 1'b0, NO_BOX},
        '{CFG_A, '{8'd128, 8'd128, 48'h6DB6_DB6D_B6DB, 8'hFF}, 1'b0, NO_BOX},
        '{CFG_A, '{8'd0,   8'd255, 48'h2000_0000_0000, 8'h00}, 1'b1, ONE_AT_33},
        // max threshold: nothing can pass
        '{CFG_B, '{8'd255, 8'd255, 48'hFFFF_FFFF_FFFF, 8'hFF}, 1'b1, EMPTY_4X4},
        // pixel mode, 2x2
        '{CFG_C, '{8'hFF,  8'hFF,  48'hFFFF_FFFF_FFFF, 8'd254}, 1'b0, NO_BOX},
        '{CFG_C, '{8'h00,  8'h00,  48'h0000_0000_0000, 8'd0},   1'b0, NO_BOX},
        '{CFG_C, '{8'h5A,  8'hA5,  48'h5555_AAAA_5555, 8'd0},   1'b0, NO_BOX},
        '{CFG_C, '{8'hFF,  8'h00,  48'hAAAA_5555_AAAA, 8'd255}, 1'b1, ONE_AT_11},
        // zero sizes act as 1x1; only pixel 0 of the block is inside
        '{CFG_D, '{8'd255, 8'd0,   48'h0000_0000_0001, 8'h00}, 1'b1, EMPTY_1X1},
        // partial blocks at the right and bottom edges
        '{CFG_E, '{8'd90,  8'd180, 48'h1234_5678_9ABC, 8'h00}, 1'b0, NO_BOX},
        '{CFG_E, '{8'd0,   8'd0,   48'h0000_0000_0000, 8'h00}, 1'b0, NO_BOX},
        '{CFG_E, '{8'd255, 8'd40,  48'h8000_0000_0007, 8'h00}, 1'b0, NO_BOX},
        '{CFG_E, '{8'd30,  8'd255, 48'h0000_0FFF_0000, 8'h00}, 1'b0, NO_BOX},
        // size shrinks mid-image, then mode flips mid-image
        '{CFG_F, '{8'h00,  8'h00,  48'h0000_0000_0000, 8'd9},  1'b0, NO_BOX},
        '{CFG_F, '{8'h00,  8'h00,  48'h0000_0000_0000, 8'd0},  1'b0, NO_BOX},
        '{CFG_G, '{8'h00,  8'h00,  48'h0000_0000_0000, 8'd50}, 1'b0, NO_BOX},
        '{CFG_H, '{8'd0,   8'd0,   48'h0000_0000_0007, 8'h00}, 1'b0, NO_BOX}
    };

    logic i_clk;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    abb_in_if  in_if ();
    abb_out_if out_if ();

    alpha_bounding_box_bc3 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the registers and of the scan state
    t_img_cfg    img_cfg = '{8'd0, 13'd64, 13'd64, MODE_BLOCK};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned lo_col  = 13'h1FFF;
    int unsigned hi_col  = 0;
    int unsigned lo_row  = 13'h1FFF;
    int unsigned hi_row  = 0;
    bit          any_hit = 0;

    t_box pending_boxes [$];
    int   bad_cnt     = 0;
    int   in_gap_pct  = 7;
    int   out_gap_pct = 7;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic note_bad(input string msg);
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS) $display("%s", msg);
    endtask

    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void mark_pixel(input int unsigned c, input int unsigned r,
                                       input int unsigned a, input int unsigned w,
                                       input int unsigned h);
        if (c >= w || r >= h || a <= img_cfg.thr) return;
        if (c < lo_col) lo_col = c;
        if (c > hi_col) hi_col = c;
        if (r < lo_row) lo_row = r;
        if (r > hi_row) hi_row = r;
        any_hit = 1'b1;
    endfunction

    // advance the scan by one item; returns 1 when the item closes the image
    function automatic bit scan_alpha_item(input t_alpha_item it, output t_box res);
        int unsigned w, h, stride, code, k, lvl;
        res = '0;
        w = fit_dim(img_cfg.width);
        h = fit_dim(img_cfg.height);
        if (img_cfg.mode == MODE_BLOCK) begin
            for (int p = 0; p < PIXELS_PER_BLK; p++) begin
                code = it.idx[CODE_W*p +: CODE_W];
                k = code - 1;
                if (code == 0) lvl = it.e0;
                else if (code == 1) lvl = it.e1;
                else if (it.e0 > it.e1) lvl = ((7 - k) * it.e0 + k * it.e1 + 3) / 7;
                else if (code <= 5) lvl = ((5 - k) * it.e0 + k * it.e1 + 2) / 5;
                else lvl = (code == 6) ? 0 : 255;
                mark_pixel(col_pos + p % BLOCK_DIM, row_pos + p / BLOCK_DIM, lvl, w, h);
            end
            stride = BLOCK_DIM;
        end else begin
            mark_pixel(col_pos, row_pos, it.pix, w, h);
            stride = 1;
        end
        col_pos += stride;
        if (col_pos < w) return 1'b0;
        col_pos = 0;
        row_pos += stride;
        if (row_pos < h) return 1'b0;
        if (any_hit) begin
            res.left  = DIM_W'(lo_col);
            res.top   = DIM_W'(lo_row);
            res.wd    = SPAN_W'(hi_col + 1 - lo_col);
            res.ht    = SPAN_W'(hi_row + 1 - lo_row);
            res.found = 1'b1;
        end else begin
            res.left  = DIM_W'(w);
            res.top   = DIM_W'(h);
            res.wd    = SPAN_W'(0 - w);
            res.ht    = SPAN_W'(0 - h);
            res.found = 1'b0;
        end
        col_pos = 0;
        row_pos = 0;
        lo_col  = 13'h1FFF;
        hi_col  = 0;
        lo_row  = 13'h1FFF;
        hi_row  = 0;
        any_hit = 1'b0;
        return 1'b1;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic push_item(input t_alpha_item it, input bit typed, input t_box typed_box,
                             output bit done);
        t_box pred;
        while ($urandom_range(0, 99) < in_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.alpha_end0    <= it.e0;
        in_if.alpha_end1    <= it.e1;
        in_if.alpha_indices <= it.idx;
        in_if.pixel_alpha   <= it.pix;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        done = scan_alpha_item(it, pred);
        if (typed) pending_boxes.push_back(typed_box);
        else if (done) pending_boxes.push_back(pred);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_boxes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one write, then a read back of the same register
    task automatic cfg_access(input int r, input logic [APB_DATA_W-1:0] val);
        for (int rd = 0; rd < 2; rd++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= (rd == 0);
            paddr   <= APB_ADDR_W'(r * 4);
            pwdata  <= val;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (rd == 1 && prdata !== val)
                note_bad($sformatf("reg %0d read: expected %0h got %0h", r, val, prdata));
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic apply_cfg(input t_img_cfg c, input bit all);
        logic [APB_DATA_W-1:0] nv [4];
        logic [APB_DATA_W-1:0] ov [4];
        drain_results();
        nv[REG_THRESHOLD] = APB_DATA_W'(c.thr);
        nv[REG_WIDTH]     = APB_DATA_W'(c.width);
        nv[REG_HEIGHT]    = APB_DATA_W'(c.height);
        nv[REG_MODE]      = APB_DATA_W'(c.mode);
        ov[REG_THRESHOLD] = APB_DATA_W'(img_cfg.thr);
        ov[REG_WIDTH]     = APB_DATA_W'(img_cfg.width);
        ov[REG_HEIGHT]    = APB_DATA_W'(img_cfg.height);
        ov[REG_MODE]      = APB_DATA_W'(img_cfg.mode);
        for (int r = 0; r < 4; r++)
            if (all || nv[r] != ov[r]) cfg_access(r, nv[r]);
        img_cfg = c;
    endtask

    // sparse blocks: code 0 often transparent, up to two random codes set; a quarter of items get fully random codes
    function automatic t_alpha_item rand_item();
        t_alpha_item it;
        it.e0  = ALPHA_W'($urandom_range(0, 255));
        it.e1  = ALPHA_W'($urandom_range(0, 255));
        it.pix = ($urandom_range(0, 3) == 0) ? ALPHA_W'($urandom_range(0, 255))
                                             : ALPHA_W'($urandom_range(0, 16));
        if ($urandom_range(0, 1) == 0) it.e0 = 8'd0;
        if ($urandom_range(0, 3) == 0) begin
            it.idx = IDX_W'({$urandom(), $urandom()});
        end else begin
            it.idx = '0;
            repeat ($urandom_range(0, 2))
                it.idx[CODE_W*$urandom_range(0, 15) +: CODE_W] = CODE_W'($urandom_range(1, 7));
        end
        return it;
    endfunction

    always @(negedge i_clk) out_if.ready <= ($urandom_range(0, 99) >= out_gap_pct);

    always @(posedge i_clk) begin : chk_box
        t_box want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_boxes.size() == 0) begin
                note_bad($sformatf("unexpected box: left=%0d top=%0d w=%0d h=%0d found=%0b",
                                   out_if.box_left, out_if.box_top, out_if.box_width,
                                   out_if.box_height, out_if.any_found));
            end else begin
                want = pending_boxes.pop_front();
                if (out_if.box_left !== want.left || out_if.box_top !== want.top ||
                    out_if.box_width !== want.wd || out_if.box_height !== want.ht ||
                    out_if.any_found !== want.found)
                    note_bad($sformatf({"box mismatch: expected %0d %0d %0d %0d %0b, ",
                                        "got %0d %0d %0d %0d %0b"},
                                       want.left, want.top, want.wd, want.ht, want.found,
                                       out_if.box_left, out_if.box_top, out_if.box_width,
                                       out_if.box_height, out_if.any_found));
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin : main_seq
        bit          done;
        t_img_cfg    c;
        int          sent;
        int          phase;
        int          nimg;
        int          imgs;
        int          extra;
        int          lim;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.alpha_end0    = '0;
        in_if.alpha_end1    = '0;
        in_if.alpha_indices = '0;
        in_if.pixel_alpha   = '0;
        out_if.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < $size(dir_tab); i++) begin
            if (dir_tab[i].cfg != img_cfg) apply_cfg(dir_tab[i].cfg, 1'b0);
            push_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].box, done);
        end

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            c.thr = ALPHA_W'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: c.thr = 8'd0;
                1: c.thr = 8'hFF;
                default: ;
            endcase
            c.mode   = t_mode'($urandom_range(0, 1));
            lim      = (c.mode == MODE_BLOCK) ? 24 : 8;
            c.width  = DIM_W'($urandom_range(0, lim));
            c.height = DIM_W'($urandom_range(0, lim));
            nimg     = $urandom_range(1, 4);
            extra    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            if (phase == 2) begin
                // widest image, zero height acts as one row
                c = '{c.thr, 13'h1FFF, 13'd0, MODE_BLOCK};
                nimg  = 1;
                extra = 0;
            end else if (phase == 5) begin
                // tallest setting, left unfinished; next phase shrinks it
                c = '{c.thr, 13'd1, 13'h1FFF, MODE_BLOCK};
                nimg  = 0;
                extra = 20;
            end
            in_gap_pct  = (phase >= 8 && phase < 13) ? 0 : 7;
            out_gap_pct = in_gap_pct;
            apply_cfg(c, 1'b1);
            imgs = 0;
            while (imgs < nimg) begin
                push_item(rand_item(), 1'b0, NO_BOX, done);
                sent++;
                if (done) imgs++;
            end
            repeat (extra) begin
                push_item(rand_item(), 1'b0, NO_BOX, done);
                sent++;
            end
            phase++;
        end

        drain_results();
        if (bad_cnt == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
